[hw/rtl/text_console_cursor_scroll_core_macros.svh]
// assertion macros used by the console core rtl
`ifndef TEXT_CONSOLE_CURSOR_SCROLL_CORE_MACROS_SVH
`define TEXT_CONSOLE_CURSOR_SCROLL_CORE_MACROS_SVH

// property that must hold at every edge out of reset
`define TCC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// condition in one cycle implies a consequence in the next
`define TCC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/tcc_pkg.sv]
// types, constants and state codes of the text console core
`default_nettype none

package tcc_pkg;

  localparam int unsigned COLUMNS_DEF = 80;
  localparam int unsigned ROWS_DEF    = 25;

  localparam logic [7:0] NEWLINE_CODE = 8'd10;

  localparam logic ACT_PUT  = 1'b0;
  localparam logic ACT_READ = 1'b1;

  typedef struct packed {
    logic       action;
    logic [7:0] char_code;
    logic [4:0] cell_row;
    logic [6:0] cell_col;
  } in_word_t;

  typedef struct packed {
    logic [7:0] result_char;
    logic       scrolled;
  } out_word_t;

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_MUL   = 9'b000000100,
    S_POS   = 9'b000001000,
    S_READ  = 9'b000010000,
    S_COPY  = 9'b000100000,
    S_STORE = 9'b001000000,
    S_NL    = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_e;

endpackage

`default_nettype wire

[hw/rtl/tcc_screen_ram.sv]
// character screen memory, one write and one registered read per cycle
`default_nettype none

module tcc_screen_ram #(
  parameter int unsigned DEPTH = tcc_pkg::COLUMNS_DEF * tcc_pkg::ROWS_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[hw/rtl/text_console_cursor_scroll_core.sv]
// text console core: cursor, newline, scroll and cell read over one screen memory
//
//   channel | direction | word                  | handshake
//   in      | input     | action/char/row/col   | in_valid_i / in_ready_o
//   out     | output    | result_char, scrolled | out_valid_o / out_ready_i
//
// a put multiplies, then adds, compares and stores, then hands off; a read also waits on the memory
// and an off-screen read hands off at once; a newline runs one subtract a cycle, one row per whole line
// past, stopping at the bottom; a scroll copies the rows up and blanks the bottom row, one cell copied
// or blanked per memory cycle; after reset the screen is blanked one cell a cycle, ready low
// a result waits in the output register; the next word is taken meanwhile
`default_nettype none

module text_console_cursor_scroll_core #(
  parameter int unsigned COLUMNS = tcc_pkg::COLUMNS_DEF,
  parameter int unsigned ROWS    = tcc_pkg::ROWS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  tcc_pkg::in_word_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tcc_pkg::out_word_t  out_data_o
);

  localparam int unsigned CELLS = ROWS * COLUMNS;
  localparam int unsigned AW    = $clog2(CELLS);
  localparam int unsigned CW    = $clog2(CELLS + 1);
  localparam int unsigned RW    = $clog2(ROWS + 1);
  localparam int unsigned PW    = $clog2(2 * CELLS + 1);

  tcc_pkg::state_e    state_q, state_d;
  tcc_pkg::in_word_t  item_q, item_d;
  tcc_pkg::out_word_t res_q, res_d;
  tcc_pkg::out_word_t out_q, out_d;
  logic               out_valid_q, out_valid_d;
  logic [CW-1:0]      cursor_col_q, cursor_col_d;
  logic [RW-1:0]      cursor_row_q, cursor_row_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic               scr_q, scr_d;
  logic [PW-1:0]      prod_q, prod_d;

  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [7:0]         mem_wdata;
  logic [AW-1:0]      mem_raddr;
  logic [7:0]         mem_rdata;

  logic [PW-1:0]      pos_w;
  logic [CW-1:0]      copy_dst;
  logic               in_fire;
  logic               read_ok;

  logic               cursor_ok;
  logic               put_store;
  logic               in_store;
  logic               store_lands;

  assign in_ready_o  = (state_q == tcc_pkg::S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // linear position: registered product plus column
  assign pos_w = prod_q + ((item_q.action == tcc_pkg::ACT_READ)
                           ? PW'(item_q.cell_col) : PW'(cursor_col_q));
  assign copy_dst = cnt_q - CW'(COLUMNS + 1);
  assign read_ok  = (32'(item_q.cell_row) < ROWS) && (32'(item_q.cell_col) < COLUMNS);

  always_comb begin
    state_d      = state_q;
    item_d       = item_q;
    res_d        = res_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    cursor_col_d = cursor_col_q;
    cursor_row_d = cursor_row_q;
    cnt_d        = cnt_q;
    scr_d        = scr_q;
    prod_d       = prod_q;
    mem_we       = 1'b0;
    mem_waddr    = '0;
    mem_wdata    = '0;
    mem_raddr    = '0;

    unique case (state_q)
      tcc_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_q[AW-1:0];
        if (cnt_q == CW'(CELLS - 1)) begin
          state_d = scr_q ? tcc_pkg::S_STORE : tcc_pkg::S_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      tcc_pkg::S_IDLE: begin
        if (in_fire) begin
          item_d = in_data_i;
          if (in_data_i.action == tcc_pkg::ACT_PUT &&
              in_data_i.char_code == tcc_pkg::NEWLINE_CODE) begin
            state_d = tcc_pkg::S_NL;
          end else begin
            state_d = tcc_pkg::S_MUL;
          end
        end
      end
      tcc_pkg::S_MUL: begin
        if (item_q.action == tcc_pkg::ACT_READ) begin
          prod_d = PW'(item_q.cell_row) * PW'(COLUMNS);
          if (read_ok) begin
            state_d = tcc_pkg::S_POS;
          end else begin
            res_d   = '0;
            state_d = tcc_pkg::S_DONE;
          end
        end else begin
          prod_d  = PW'(cursor_row_q) * PW'(COLUMNS);
          state_d = tcc_pkg::S_POS;
        end
      end
      tcc_pkg::S_POS: begin
        if (item_q.action == tcc_pkg::ACT_READ) begin
          mem_raddr = pos_w[AW-1:0];
          state_d   = tcc_pkg::S_READ;
        end else if (pos_w >= PW'(CELLS)) begin
          scr_d   = 1'b1;
          cnt_d   = CW'(COLUMNS);
          state_d = tcc_pkg::S_COPY;
        end else begin
          mem_we       = 1'b1;
          mem_waddr    = pos_w[AW-1:0];
          mem_wdata    = item_q.char_code;
          cursor_col_d = cursor_col_q + 1'b1;
          res_d        = '{result_char: item_q.char_code, scrolled: 1'b0};
          state_d      = tcc_pkg::S_DONE;
        end
      end
      tcc_pkg::S_READ: begin
        res_d   = '{result_char: mem_rdata, scrolled: 1'b0};
        state_d = tcc_pkg::S_DONE;
      end
      tcc_pkg::S_COPY: begin
        // read one row below, write what the previous cycle read
        if (cnt_q < CW'(CELLS)) begin
          mem_raddr = cnt_q[AW-1:0];
        end
        if (cnt_q > CW'(COLUMNS)) begin
          mem_we    = 1'b1;
          mem_waddr = copy_dst[AW-1:0];
          mem_wdata = mem_rdata;
        end
        if (cnt_q == CW'(CELLS)) begin
          cnt_d   = CW'(CELLS - COLUMNS);
          state_d = tcc_pkg::S_CLEAR;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      tcc_pkg::S_STORE: begin
        mem_we       = 1'b1;
        mem_waddr    = AW'(CELLS - COLUMNS);
        mem_wdata    = item_q.char_code;
        cursor_row_d = RW'(ROWS - 1);
        cursor_col_d = CW'(1);
        scr_d        = 1'b0;
        res_d        = '{result_char: item_q.char_code, scrolled: 1'b1};
        state_d      = tcc_pkg::S_DONE;
      end
      tcc_pkg::S_NL: begin
        // whole lines run past, one subtract per cycle, stop at the bottom
        if (cursor_col_q >= CW'(COLUMNS) && cursor_row_q < RW'(ROWS)) begin
          cursor_col_d = cursor_col_q - CW'(COLUMNS);
          cursor_row_d = cursor_row_q + 1'b1;
        end else begin
          if (cursor_row_q < RW'(ROWS)) begin
            cursor_row_d = cursor_row_q + 1'b1;
          end
          cursor_col_d = '0;
          res_d        = '{result_char: tcc_pkg::NEWLINE_CODE, scrolled: 1'b0};
          state_d      = tcc_pkg::S_DONE;
        end
      end
      tcc_pkg::S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          state_d     = tcc_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = tcc_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= tcc_pkg::S_CLEAR;
      out_valid_q  <= 1'b0;
      cursor_col_q <= '0;
      cursor_row_q <= '0;
      cnt_q        <= '0;
      scr_q        <= 1'b0;
    end else begin
      state_q      <= state_d;
      out_valid_q  <= out_valid_d;
      cursor_col_q <= cursor_col_d;
      cursor_row_q <= cursor_row_d;
      cnt_q        <= cnt_d;
      scr_q        <= scr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    res_q  <= res_d;
    out_q  <= out_d;
    prod_q <= prod_d;
  end

  tcc_screen_ram #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_screen (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign cursor_ok   = (cursor_col_q <= CW'(CELLS)) && (cursor_row_q <= RW'(ROWS));
  assign put_store   = (state_q == tcc_pkg::S_POS) && mem_we;
  assign in_store    = (state_q == tcc_pkg::S_STORE);
  assign store_lands = (cursor_row_q == RW'(ROWS - 1)) && (cursor_col_q == CW'(1))
                       && res_q.scrolled;

`include "text_console_cursor_scroll_core_macros.svh"

  `TCC_ASSERT(a_cursor_bounds, clk_i, rst_ni, cursor_ok, "cursor out of range")
  `TCC_ASSERT(a_put_in_screen, clk_i, rst_ni, !put_store || (pos_w < PW'(CELLS)), "put beyond screen")
  `TCC_ASSERT(a_no_scroll_idle, clk_i, rst_ni, !in_ready_o || !scr_q, "ready during scroll")
  `TCC_ASSERT_NEXT(a_scroll_lands, clk_i, rst_ni, in_store, store_lands, "bad scroll landing")

endmodule

`default_nettype wire

[tb/sv/tb_text_console_cursor_scroll_core.sv]
// testbench for the text console core: directed table, random lines of text, shadow screen check
module tb_text_console_cursor_scroll_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned COLUMNS      = tcc_pkg::COLUMNS_DEF;
  localparam int unsigned ROWS         = tcc_pkg::ROWS_DEF;
  localparam int unsigned CELLS        = ROWS * COLUMNS;
  localparam int unsigned RANDOM_WORDS = 730;
  localparam int unsigned QUIET_TAIL   = 120;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned CYCLE_LIMIT  = 8000000;
  localparam int unsigned TABLE_ROWS   = 22;

  typedef struct packed {
    tcc_pkg::in_word_t  word;
    logic               typed;
    tcc_pkg::out_word_t want;
  } stim_row_t;

  logic               clk_i = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  tcc_pkg::in_word_t  in_data = '0;
  logic               in_ready_o;
  logic               out_valid_o;
  logic               out_ready = 1'b0;
  tcc_pkg::out_word_t out_data_o;

  // shadow of the screen and the cursor
  logic [7:0]  screen_shadow [CELLS];
  int unsigned shadow_col;
  int unsigned shadow_row;

  tcc_pkg::out_word_t pending_results [$];
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned cycle_count = 0;
  bit          idle_off = 1'b0;
  bit          hold_request = 1'b0;

  // directed words: expected value typed in only where it is obvious
  stim_row_t directed_rows [TABLE_ROWS] = '{
    '{'{tcc_pkg::ACT_READ, 8'h00, 5'd0,  7'd0},   1'b1, '{8'h00, 1'b0}},
    '{'{tcc_pkg::ACT_READ, 8'h00, 5'd24, 7'd79},  1'b1, '{8'h00, 1'b0}},
    '{'{tcc_pkg::ACT_READ, 8'hff, 5'd31, 7'd127}, 1'b1, '{8'h00, 1'b0}},
    '{'{tcc_pkg::ACT_READ, 8'h00, 5'd25, 7'd0},   1'b1, '{8'h00, 1'b0}},
    '{'{tcc_pkg::ACT_READ, 8'h00, 5'd0,  7'd80},  1'b1, '{8'h00, 1'b0}},
    '{'{tcc_pkg::ACT_PUT,  8'h41, 5'd0,  7'd0},   1'b1, '{8'h41, 1'b0}},
    '{'{tcc_pkg::ACT_PUT,  8'hff, 5'd0,  7'd0},   1'b1, '{8'hff, 1'b0}},
    '{'{tcc_pkg::ACT_PUT,  8'h00, 5'd0,  7'd0},   1'b1, '{8'h00, 1'b0}},
    '{'{tcc_pkg::ACT_READ, 8'h00, 5'd0,  7'd0},   1'b0, '{8'h00, 1'b0}},
    '{'{tcc_pkg::ACT_READ, 8'h00, 5'd0,  7'd1},   1'b0, '{8'h00, 1'b0}},
    '{'{tcc_pkg::ACT_PUT, tcc_pkg::NEWLINE_CODE, 5'd0, 7'd0}, 1'b1,
      '{tcc_pkg::NEWLINE_CODE, 1'b0}},
    '{'{tcc_pkg::ACT_PUT, tcc_pkg::NEWLINE_CODE, 5'd0, 7'd0}, 1'b1,
      '{tcc_pkg::NEWLINE_CODE, 1'b0}},
    '{'{tcc_pkg::ACT_PUT,  8'h0b, 5'd0,  7'd0},   1'b1, '{8'h0b, 1'b0}},
    '{'{tcc_pkg::ACT_PUT,  8'h09, 5'd0,  7'd0},   1'b1, '{8'h09, 1'b0}},
    '{'{tcc_pkg::ACT_READ, 8'h00, 5'd2,  7'd0},   1'b0, '{8'h00, 1'b0}},
    '{'{tcc_pkg::ACT_READ, tcc_pkg::NEWLINE_CODE, 5'd2, 7'd1}, 1'b0, '{8'h00, 1'b0}},
    '{'{tcc_pkg::ACT_READ, 8'h00, 5'd31, 7'd0},   1'b1, '{8'h00, 1'b0}},
    '{'{tcc_pkg::ACT_READ, 8'h00, 5'd0,  7'd127}, 1'b1, '{8'h00, 1'b0}},
    '{'{tcc_pkg::ACT_PUT,  8'h55, 5'd31, 7'd127}, 1'b1, '{8'h55, 1'b0}},
    '{'{tcc_pkg::ACT_PUT,  8'h80, 5'd0,  7'd0},   1'b1, '{8'h80, 1'b0}},
    '{'{tcc_pkg::ACT_PUT, tcc_pkg::NEWLINE_CODE, 5'd0, 7'd0}, 1'b1,
      '{tcc_pkg::NEWLINE_CODE, 1'b0}},
    '{'{tcc_pkg::ACT_READ, 8'h00, 5'd1,  7'd0},   1'b0, '{8'h00, 1'b0}}
  };

  text_console_cursor_scroll_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // apply one accepted word to the shadow console and return its result
  function automatic tcc_pkg::out_word_t console_apply(tcc_pkg::in_word_t w);
    tcc_pkg::out_word_t r;
    int unsigned pos;
    int unsigned nrow;
    r = '0;
    if (w.action == tcc_pkg::ACT_READ) begin
      if (w.cell_row < ROWS && w.cell_col < COLUMNS)
        r.result_char = screen_shadow[w.cell_row * COLUMNS + w.cell_col];
    end else if (w.char_code == tcc_pkg::NEWLINE_CODE) begin
      // a run-on line counts as the rows it spilled into
      nrow = shadow_row + shadow_col / COLUMNS + 1;
      shadow_row = (nrow > ROWS) ? ROWS : nrow;
      shadow_col = 0;
      r.result_char = w.char_code;
    end else begin
      pos = shadow_row * COLUMNS + shadow_col;
      if (pos >= CELLS) begin
        for (int i = 0; i < CELLS - COLUMNS; i++) screen_shadow[i] = screen_shadow[i + COLUMNS];
        for (int i = CELLS - COLUMNS; i < CELLS; i++) screen_shadow[i] = 8'h00;
        shadow_row = ROWS - 1;
        shadow_col = 0;
        pos = shadow_row * COLUMNS;
        r.scrolled = 1'b1;
      end
      screen_shadow[pos] = w.char_code;
      shadow_col++;
      r.result_char = w.char_code;
    end
    return r;
  endfunction

  task automatic note_mismatch(string what, logic [7:0] want, logic [7:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch on %s at result %0d: expected %0h, got %0h",
               what, results_seen, want, got);
  endtask

  // offer one word, hold it until taken, then maybe leave a gap
  task automatic offer_word(input tcc_pkg::in_word_t w, input bit typed,
                            input tcc_pkg::out_word_t want);
    tcc_pkg::out_word_t predicted;
    in_data  <= w;
    in_valid <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = console_apply(w);
    pending_results.push_back(typed ? want : predicted);
    if (!idle_off && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  function automatic tcc_pkg::in_word_t random_read();
    tcc_pkg::in_word_t w;
    w.action    = tcc_pkg::ACT_READ;
    w.char_code = 8'($urandom);
    w.cell_row  = 5'($urandom);
    w.cell_col  = 7'($urandom);
    if ($urandom_range(0, 7) != 0) begin
      w.cell_row = 5'($urandom_range(0, ROWS - 1));
      w.cell_col = 7'($urandom_range(0, COLUMNS - 1));
    end
    return w;
  endfunction

  function automatic tcc_pkg::in_word_t random_put();
    tcc_pkg::in_word_t w;
    w.action   = tcc_pkg::ACT_PUT;
    w.cell_row = 5'($urandom);
    w.cell_col = 7'($urandom);
    // an occasional stray newline inside a line is left in on purpose
    w.char_code = 8'($urandom_range(0, 255));
    return w;
  endfunction

  always @(posedge clk_i) begin
    if (rst_n && out_valid_o && out_ready) begin
      if (pending_results.size() == 0) begin
        note_mismatch("unexpected word", 8'h00, out_data_o.result_char);
      end else begin
        if (out_data_o.result_char !== pending_results[0].result_char)
          note_mismatch("result_char", pending_results[0].result_char, out_data_o.result_char);
        if (out_data_o.scrolled !== pending_results[0].scrolled)
          note_mismatch("scrolled", 8'(pending_results[0].scrolled), 8'(out_data_o.scrolled));
        void'(pending_results.pop_front());
      end
      results_seen++;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** text_console_cursor_scroll_core: FAILED **");
      $finish;
    end
  end

  // receiver side: short random stalls plus one long hold-off on request
  initial begin : rx_side
    int unsigned hold_left;
    hold_left = 0;
    wait (rst_n);
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left != 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (!idle_off && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        hold_left = $urandom_range(0, 5);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : tx_side
    int unsigned       sent;
    int unsigned       line_len;
    tcc_pkg::in_word_t nl_word;
    for (int i = 0; i < CELLS; i++) screen_shadow[i] = 8'h00;
    shadow_col = 0;
    shadow_row = 0;
    sent = 0;
    repeat (10) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      offer_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].want);

    // random text: mostly short lines, a few long ones that run on past the row
    while (sent < RANDOM_WORDS) begin
      line_len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 170) : $urandom_range(0, 24);
      for (int k = 0; k < line_len && sent < RANDOM_WORDS; k++) begin
        if ($urandom_range(0, 3) == 0) offer_word(random_read(), 1'b0, '0);
        else offer_word(random_put(), 1'b0, '0);
        sent++;
        if (sent == 200) hold_request = 1'b1;
        if (sent >= RANDOM_WORDS - QUIET_TAIL) idle_off = 1'b1;
      end
      nl_word.action    = tcc_pkg::ACT_PUT;
      nl_word.char_code = tcc_pkg::NEWLINE_CODE;
      nl_word.cell_row  = 5'($urandom);
      nl_word.cell_col  = 7'($urandom);
      offer_word(nl_word, 1'b0, '0);
      sent++;
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("** text_console_cursor_scroll_core: PASSED **");
    end else begin
      $display("** text_console_cursor_scroll_core: FAILED **");
    end
    $finish;
  end

endmodule
